FILE: rtl/fsbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_pkg: shared types and constants for the flash sector blank check
// Beat layouts, verdict codes, the CRC-32 polynomial and the byte-wide
// CRC update.
// ----------------------------------------------------------------------------
package fsbc_pkg;

	localparam int SECTOR_BYTES_DEF = 4096;
	localparam int NUM_CHUNKS_DEF   = 16;

	localparam int CHUNK_BYTES = 256;
	localparam int CHUNK_SHIFT = 8;
	localparam int MAP_W       = 16;
	localparam int COUNT_OUT_W = 13;
	localparam int OFFS_OUT_W  = 12;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [7:0] BYTE_ERASED = 8'hFF;
	localparam logic [7:0] BYTE_ZERO   = 8'h00;

	localparam logic [1:0] VERDICT_BLANK     = 2'd0;
	localparam logic [1:0] VERDICT_ALL_ZERO  = 2'd1;
	localparam logic [1:0] VERDICT_POPULATED = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]             verdict;
		logic [COUNT_OUT_W-1:0] non_erased_count;
		logic [COUNT_OUT_W-1:0] nonzero_count;
		logic                   any_data;
		logic [OFFS_OUT_W-1:0]  first_offset;
		logic [OFFS_OUT_W-1:0]  last_offset;
		logic [MAP_W-1:0]       chunk_map;
		logic [31:0]            crc_value;
	} out_beat_t;

	// CRC accumulator control
	typedef struct packed {
		logic advance;  // absorb one byte
		logic restart;  // reload the initial value instead
	} crc_ctl_t;

	// reflected CRC-32, one byte, eight bit steps
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: rtl/flash_sector_blank_check_crc32_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_sector_blank_check_crc32_top: sector blank check with CRC-32
// Streams a sector byte by byte and reports erase statistics and the CRC.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid / byte_stall / byte_beat): one sector byte per
//   beat in address order; last_byte marks the final byte of a scan.
//   report channel (report_valid / report_stall / report_beat): one beat per
//   scan, with the verdict, both miss counts, first/last data offsets, the
//   chunk map and the final inverted CRC-32.
// Timing:
//   One byte per cycle sustained while byte_stall is low. A byte waits in
//   the input register, and the CRC, counters and offsets take it in as it
//   moves on; a final byte's report is registered in the output register as
//   it moves on, and is held there until taken. The CRC step is an eight-bit
//   unrolled update and sets the cycle path.
// Stalls:
//   Non-final bytes never wait on the report side. A final byte waits in the
//   input register only while an older report is still held by report_stall;
//   byte_stall then rises until the report slot frees.
// Reset:
//   arst_n clears both registers' valid flags and the scan state (CRC to all
//   ones, position, counts, offsets and chunk map to zero). After each report
//   the scan state returns to the same values for the next sector.
// ----------------------------------------------------------------------------
module flash_sector_blank_check_crc32_top #(
	parameter int SECTOR_BYTES = fsbc_pkg::SECTOR_BYTES_DEF,
	parameter int NUM_CHUNKS   = fsbc_pkg::NUM_CHUNKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  fsbc_pkg::in_beat_t  byte_beat,
	output logic                report_valid,
	input  logic                report_stall,
	output fsbc_pkg::out_beat_t report_beat
);

	// position spans 0..SECTOR_BYTES-1, counts span 0..SECTOR_BYTES
	localparam int POS_W = $clog2(SECTOR_BYTES);
	localparam int CNT_W = $clog2(SECTOR_BYTES + 1);
	localparam int CHUNK_LIM = (NUM_CHUNKS < fsbc_pkg::MAP_W) ? NUM_CHUNKS : fsbc_pkg::MAP_W;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(SECTOR_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SECTOR_BYTES);

	// input register
	logic               valid_s1;
	fsbc_pkg::in_beat_t beat_s1;

	// scan state
	logic [POS_W-1:0]           pos_q;
	logic [CNT_W-1:0]           erased_miss_q;
	logic [CNT_W-1:0]           zero_miss_q;
	logic                       seen_q;
	logic [POS_W-1:0]           first_q;
	logic [POS_W-1:0]           last_q;
	logic [fsbc_pkg::MAP_W-1:0] map_q;

	// output register
	logic                valid_q;
	fsbc_pkg::out_beat_t report_q;

	// next-state logic
	logic                       fire;
	logic                       not_erased;
	logic                       not_zero;
	logic [POS_W-1:0]           chunk_idx;
	logic [fsbc_pkg::MAP_W-1:0] map_set;
	logic [CNT_W-1:0]           erased_miss_d;
	logic [CNT_W-1:0]           zero_miss_d;
	logic                       seen_d;
	logic [POS_W-1:0]           first_d;
	logic [POS_W-1:0]           last_d;
	logic [fsbc_pkg::MAP_W-1:0] map_d;
	logic [1:0]                 verdict_d;
	logic [31:0]                crc_next;
	fsbc_pkg::crc_ctl_t         crc_ctl;

	// a final byte needs the report slot; others always move
	assign fire = valid_s1 && (!beat_s1.last_byte || !valid_q || !report_stall);
	assign byte_stall = valid_s1 && !fire;

	assign not_erased = (beat_s1.data_byte != fsbc_pkg::BYTE_ERASED);
	assign not_zero   = (beat_s1.data_byte != fsbc_pkg::BYTE_ZERO);
	assign chunk_idx  = pos_q >> fsbc_pkg::CHUNK_SHIFT;

	// chunk decode; chunks past NUM_CHUNKS or the map width set nothing
	always_comb begin
		for (int k = 0; k < fsbc_pkg::MAP_W; k++) begin
			map_set[k] = (k < CHUNK_LIM) && (chunk_idx == POS_W'(k));
		end
	end

	always_comb begin
		erased_miss_d = erased_miss_q;
		zero_miss_d   = zero_miss_q;
		seen_d        = seen_q;
		first_d       = first_q;
		last_d        = last_q;
		map_d         = map_q;
		if (not_erased) begin
			if (erased_miss_q != CNT_MAX) begin
				erased_miss_d = erased_miss_q + CNT_W'(1);
			end
			if (!seen_q) begin
				first_d = pos_q;
			end
			seen_d = 1'b1;
			last_d = pos_q;
			map_d  = map_q | map_set;
		end
		if (not_zero && zero_miss_q != CNT_MAX) begin
			zero_miss_d = zero_miss_q + CNT_W'(1);
		end
		if (erased_miss_d == '0) begin
			verdict_d = fsbc_pkg::VERDICT_BLANK;
		end else if (zero_miss_d == '0) begin
			verdict_d = fsbc_pkg::VERDICT_ALL_ZERO;
		end else begin
			verdict_d = fsbc_pkg::VERDICT_POPULATED;
		end
	end

	assign crc_ctl.advance = fire;
	assign crc_ctl.restart = beat_s1.last_byte;

	fsbc_crc32 u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (crc_ctl),
		.data_byte (beat_s1.data_byte),
		.crc_next  (crc_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			beat_s1 <= byte_beat;
		end
	end

	// scan state; cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			erased_miss_q <= '0;
			zero_miss_q   <= '0;
			seen_q        <= 1'b0;
			first_q       <= '0;
			last_q        <= '0;
			map_q         <= '0;
		end else if (fire) begin
			if (beat_s1.last_byte) begin
				pos_q         <= '0;
				erased_miss_q <= '0;
				zero_miss_q   <= '0;
				seen_q        <= 1'b0;
				first_q       <= '0;
				last_q        <= '0;
				map_q         <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
				erased_miss_q <= erased_miss_d;
				zero_miss_q   <= zero_miss_d;
				seen_q        <= seen_d;
				first_q       <= first_d;
				last_q        <= last_d;
				map_q         <= map_d;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire && beat_s1.last_byte) begin
			valid_q <= 1'b1;
		end else if (!report_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && beat_s1.last_byte) begin
			report_q.verdict          <= verdict_d;
			report_q.non_erased_count <= fsbc_pkg::COUNT_OUT_W'(erased_miss_d);
			report_q.nonzero_count    <= fsbc_pkg::COUNT_OUT_W'(zero_miss_d);
			report_q.any_data         <= seen_d;
			report_q.first_offset     <= fsbc_pkg::OFFS_OUT_W'(first_d);
			report_q.last_offset      <= fsbc_pkg::OFFS_OUT_W'(last_d);
			report_q.chunk_map        <= map_d;
			report_q.crc_value        <= ~crc_next;
		end
	end

	assign report_valid = valid_q;
	assign report_beat  = report_q;

`ifndef SYNTHESIS
	// a final byte always lands a report beat
	a_last_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && beat_s1.last_byte) |=> report_valid)
		else $error("final byte did not produce a report");

	// the scan state starts over after a final byte
	a_scan_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && beat_s1.last_byte) |=> (pos_q == '0 && erased_miss_q == '0 && map_q == '0))
		else $error("scan state not cleared after report");

	// only a blocked final byte holds the input side
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && beat_s1.last_byte && valid_q && report_stall))
		else $error("byte_stall without a blocked report");

	// data flag tracks the non-erased count
	a_seen_count: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q == (erased_miss_q != '0))
		else $error("seen flag and miss count disagree");

	// counts saturate at the sector size
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(erased_miss_q <= CNT_MAX) && (zero_miss_q <= CNT_MAX))
		else $error("miss count beyond sector size");
`endif

endmodule

FILE: rtl/fsbc_crc32.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_crc32: running CRC-32 accumulator
// Absorbs one byte per advance; restart reloads the initial value.
// ----------------------------------------------------------------------------
module fsbc_crc32 (
	input  logic               clk,
	input  logic               arst_n,
	input  fsbc_pkg::crc_ctl_t ctl,
	input  logic [7:0]         data_byte,
	output logic [31:0]        crc_next
);

	logic [31:0] crc_q;

	assign crc_next = fsbc_pkg::crc32_byte(crc_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= fsbc_pkg::CRC_INIT;
		end else if (ctl.advance) begin
			crc_q <= ctl.restart ? fsbc_pkg::CRC_INIT : crc_next;
		end
	end

endmodule

FILE: dv/fsbc_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsbc_scan_checker: scoreboard for the sector blank check
// Follows every accepted byte beat with an independent scan model and
// compares each accepted report beat, field by field, with the oldest
// predicted report.
// ----------------------------------------------------------------------------
module fsbc_scan_checker #(
	parameter int SECTOR_BYTES = fsbc_pkg::SECTOR_BYTES_DEF,
	parameter int NUM_CHUNKS   = fsbc_pkg::NUM_CHUNKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic                byte_stall,
	input  fsbc_pkg::in_beat_t  byte_beat,
	input  logic                report_valid,
	input  logic                report_stall,
	input  fsbc_pkg::out_beat_t report_beat,
	output int                  fail_count,
	output int                  pending
);
	import fsbc_pkg::*;

	logic [31:0]      crc_run;
	logic [31:0]      scan_pos;  // offset of the next byte
	logic [31:0]      erased_misses;
	logic [31:0]      zero_misses;
	logic             data_seen;
	logic [31:0]      first_hit;
	logic [31:0]      last_hit;
	logic [MAP_W-1:0] chunk_hits;
	out_beat_t        expected_reports[$];

	function automatic logic [31:0] sat_count(input logic [31:0] v);
		return (v < SECTOR_BYTES) ? v + 1 : SECTOR_BYTES;
	endfunction

	task automatic clear_scan();
		crc_run       = CRC_INIT;
		scan_pos      = '0;
		erased_misses = '0;
		zero_misses   = '0;
		data_seen     = 1'b0;
		first_hit     = '0;
		last_hit      = '0;
		chunk_hits    = '0;
	endtask

	task automatic absorb_byte(input in_beat_t b);
		logic [31:0] chunk;
		out_beat_t   r;
		chunk = scan_pos >> CHUNK_SHIFT;
		if (b.data_byte != BYTE_ERASED) begin
			erased_misses = sat_count(erased_misses);
			if (!data_seen)
				first_hit = scan_pos;
			data_seen = 1'b1;
			last_hit  = scan_pos;
			if (chunk < NUM_CHUNKS && chunk < MAP_W)
				chunk_hits[chunk[3:0]] = 1'b1;
		end
		if (b.data_byte != BYTE_ZERO)
			zero_misses = sat_count(zero_misses);
		// reflected CRC-32, LSB first
		crc_run = crc_run ^ {24'h0, b.data_byte};
		repeat (8)
			crc_run = crc_run[0] ? ({1'b0, crc_run[31:1]} ^ CRC_POLY) : {1'b0, crc_run[31:1]};
		if (scan_pos < SECTOR_BYTES - 1)
			scan_pos = scan_pos + 1;
		if (b.last_byte) begin
			if (erased_misses == 0)
				r.verdict = VERDICT_BLANK;
			else if (zero_misses == 0)
				r.verdict = VERDICT_ALL_ZERO;
			else
				r.verdict = VERDICT_POPULATED;
			r.non_erased_count = erased_misses[COUNT_OUT_W-1:0];
			r.nonzero_count    = zero_misses[COUNT_OUT_W-1:0];
			r.any_data         = data_seen;
			r.first_offset     = data_seen ? first_hit[OFFS_OUT_W-1:0] : '0;
			r.last_offset      = data_seen ? last_hit[OFFS_OUT_W-1:0] : '0;
			r.chunk_map        = chunk_hits;
			r.crc_value        = ~crc_run;
			expected_reports.push_back(r);
			clear_scan();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("report %s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_report(input out_beat_t got);
		out_beat_t want;
		if (expected_reports.size() == 0) begin
			$error("report beat with no scan outstanding: 0x%0h", got);
			fail_count++;
		end else begin
			want = expected_reports.pop_front();
			check_field("verdict", want.verdict, got.verdict);
			check_field("non_erased_count", want.non_erased_count, got.non_erased_count);
			check_field("nonzero_count", want.nonzero_count, got.nonzero_count);
			check_field("any_data", want.any_data, got.any_data);
			check_field("first_offset", want.first_offset, got.first_offset);
			check_field("last_offset", want.last_offset, got.last_offset);
			check_field("chunk_map", want.chunk_map, got.chunk_map);
			check_field("crc_value", want.crc_value, got.crc_value);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_reports.delete();
			fail_count = 0;
		end else begin
			if (report_valid && !report_stall)
				check_report(report_beat);
			if (byte_valid && !byte_stall)
				absorb_byte(byte_beat);
		end
		pending = expected_reports.size();
	end

endmodule

FILE: dv/tb_flash_sector_blank_check_crc32_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_sector_blank_check_crc32_top: sector blank check testbench
// Streams directed and random sector scans into the block with random source
// gaps and report stalls; a separate scoreboard predicts and checks every
// report beat, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_flash_sector_blank_check_crc32_top;
	import fsbc_pkg::*;

	localparam int RANDOM_BYTES = 1550;     // bytes in random scans
	localparam int CYCLE_LIMIT  = 200_000;  // watchdog limit in cycles
	localparam int DRAIN_CYCLES = 8;        // idle wait after the last report is checked

	// byte content styles for one scan
	typedef enum int {
		FILL_ERASED,
		FILL_ZERO,
		FILL_SPARSE,
		FILL_RANDOM,
		FILL_MIXED,
		FILL_NONBLANK,
		FILL_PATCHY
	} fill_t;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      byte_valid   = 1'b0;
	logic      byte_stall;
	in_beat_t  byte_beat    = '0;
	logic      report_valid;
	logic      report_stall = 1'b1;
	out_beat_t report_beat;

	int          fail_count;
	int          pending;
	int          cycles      = 0;
	int          report_hold = 0;
	int unsigned stall_draw;
	bit          quiet       = 1'b0;  // no gaps and no stalls while set
	logic [MAP_W-1:0] patch_mask = '0;  // chunks that carry data in a patchy scan

	always #1 clk = ~clk;

	flash_sector_blank_check_crc32_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report_beat  (report_beat)
	);

	fsbc_scan_checker i_scan_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_beat    (byte_beat),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report_beat  (report_beat),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// Report side: after each accepted beat draw a random stall length.
	// The hold only counts down while a report is waiting, so the stall
	// really lands on the next report and, for back-to-back short scans,
	// pushes back on the final byte through byte_stall.
	always @(posedge clk) begin
		if (!arst_n) begin
			report_stall <= 1'b1;
			report_hold  <= 0;
		end else if (report_valid && !report_stall) begin
			stall_draw = quiet ? 0 : $urandom_range(0, 7);
			report_stall <= (stall_draw != 0);
			report_hold  <= stall_draw;
		end else if (report_hold != 0) begin
			if (report_valid) begin
				report_hold <= report_hold - 1;
				if (report_hold == 1)
					report_stall <= 1'b0;
			end
		end else begin
			report_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// One byte beat: optional random gap of idle cycles, then hold the beat
	// until accepted. Valid stays high across gapless beats so it is never
	// dropped and raised in the same step. Called and returns at a rising edge.
	task automatic send_byte(input logic [7:0] d, input logic l);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_beat  <= '{data_byte: d, last_byte: l};
		do @(posedge clk); while (byte_stall);
	endtask

	function automatic logic [7:0] pick_byte(input fill_t fill, input int offset);
		case (fill)
			FILL_ERASED:   return BYTE_ERASED;
			FILL_ZERO:     return BYTE_ZERO;
			FILL_SPARSE:   return ($urandom_range(0, 7) == 0) ? 8'($urandom) : BYTE_ERASED;
			FILL_NONBLANK: return 8'($urandom_range(1, 254));
			FILL_PATCHY: begin
				// data only in the chunks picked by patch_mask, thinly spread
				if (patch_mask[(offset >> CHUNK_SHIFT) % MAP_W] && $urandom_range(0, 31) == 0)
					return 8'($urandom);
				return BYTE_ERASED;
			end
			FILL_MIXED: begin
				case ($urandom_range(0, 3))
					0:       return BYTE_ERASED;
					1:       return BYTE_ZERO;
					default: return 8'($urandom);
				endcase
			end
			default:       return 8'($urandom);
		endcase
	endfunction

	task automatic run_scan(input int len, input fill_t fill);
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(fill, i), i == len - 1);
	endtask

	initial begin
		string check_str = "123456789";
		int    scans = 0;
		int    random_bytes = 0;
		int    len;
		fill_t fill;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed scans ----
		// single-byte scans: blank, all zero, populated
		send_byte(BYTE_ERASED, 1'b1);
		send_byte(BYTE_ZERO, 1'b1);
		send_byte(8'h80, 1'b1);
		// one zero and one erased byte: populated, data at offset 0 only
		send_byte(BYTE_ZERO, 1'b0);
		send_byte(BYTE_ERASED, 1'b1);
		// leading erased bytes push the first data offset out
		send_byte(BYTE_ERASED, 1'b0);
		send_byte(BYTE_ERASED, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(BYTE_ERASED, 1'b0);
		send_byte(8'hFE, 1'b1);
		// standard CRC-32 check string
		for (int i = 0; i < 9; i++)
			send_byte(check_str[i], i == 8);
		// all zero over several bytes
		send_byte(BYTE_ZERO, 1'b0);
		send_byte(BYTE_ZERO, 1'b0);
		send_byte(BYTE_ZERO, 1'b1);
		// short scan with no erased and no zero byte
		run_scan(12, FILL_NONBLANK);

		// ---- random scans ----
		// Mostly short scans of varied content; every 25th scan spans a few
		// chunks with data in a random set of them to exercise the map.
		while (random_bytes < RANDOM_BYTES) begin
			quiet = ($urandom_range(0, 5) == 0);
			if (scans % 25 == 12) begin
				patch_mask = 16'($urandom);
				len = $urandom_range(CHUNK_BYTES + 1, 3 * CHUNK_BYTES);
				run_scan(len, FILL_PATCHY);
			end else begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
				case ($urandom_range(0, 9))
					0:       fill = FILL_ERASED;
					1:       fill = FILL_ZERO;
					2, 3:    fill = FILL_SPARSE;
					4, 5, 6: fill = FILL_RANDOM;
					default: fill = FILL_MIXED;
				endcase
				run_scan(len, fill);
			end
			random_bytes += len;
			scans++;
		end

		// ---- drain ----
		byte_valid <= 1'b0;
		quiet = 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fsbc_pkg.sv
rtl/fsbc_crc32.sv
rtl/flash_sector_blank_check_crc32_top.sv
dv/fsbc_scan_checker.sv
dv/tb_flash_sector_blank_check_crc32_top.sv
